@@ design/crfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crfr_pkg
// Shared types and constants for the checksummed frame receiver.
// ----------------------------------------------------------------------------
package crfr_pkg;

  localparam int BUF_DEPTH_DEF   = 2048;
  localparam int MAX_IMAGE_DEF   = 262144;

  localparam int APB_ADDR_W = 5;

  localparam logic [2:0] REG_HEAD    = 3'd0;
  localparam logic [2:0] REG_TAIL    = 3'd1;
  localparam logic [2:0] REG_OWN_ID  = 3'd2;
  localparam logic [2:0] REG_MIN_LEN = 3'd3;
  localparam logic [2:0] REG_MAX_LEN = 3'd4;
  localparam logic [2:0] REG_CMD_STA = 3'd5;
  localparam logic [2:0] REG_CMD_UPD = 3'd6;
  localparam logic [2:0] REG_CMD_END = 3'd7;

  localparam logic [1:0] EV_OWN     = 2'd0;
  localparam logic [1:0] EV_OTHER   = 2'd1;
  localparam logic [1:0] EV_DISCARD = 2'd2;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_STARTED  = 2'd1;
  localparam logic [1:0] PH_UPDATING = 2'd2;
  localparam logic [1:0] PH_FINISHED = 2'd3;

  localparam logic [15:0] ANY_ID       = 16'hFFFF;
  localparam logic [10:0] FRAME_OVH    = 11'd12;
  localparam logic [10:0] MIN_UPD_LEN  = 11'd10;
  localparam logic [10:0] MIN_LEN_FLOOR = 11'd3;
  localparam int          DISC_MAX     = 4095;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  cmd;
    logic [15:0] tgt;
    logic [15:0] snd;
    logic [10:0] flen;
    logic [11:0] disc;
    logic [1:0]  phase;
    logic [15:0] chunk;
    logic        status;
    logic [31:0] woff;
    logic [10:0] plen;
  } row_t;

endpackage
`default_nettype wire

@@ design/checksummed_frame_receiver.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// checksummed_frame_receiver
// Byte-stream deframer with sum8 check and update session tracking.
// ----------------------------------------------------------------------------
// Each accepted byte goes into a ring buffer RAM, then a sequencer scans the
// buffer for a head byte, length, checksum and tail. A byte that leaves fewer
// buffered bytes than the minimum frame length holds in_stall only through the
// check and flush states. A scan reads each byte in S_SCAN/S_SCAN_D until it
// finds a head, reads the length in S_LEN0/S_LEN1 and checks it in S_LCHK, then
// reads each byte after the head through S_BODY/S_BODY_D; a failed check
// resumes the scan at the byte after the candidate head, so the bytes of the
// candidate are read again. The single RAM read port sets the pace. Up to two
// results per byte; in_stall stays high until the last one has been handed to
// the output register.
module checksummed_frame_receiver #(
  parameter int BUF_DEPTH       = crfr_pkg::BUF_DEPTH_DEF,
  parameter int MAX_IMAGE_BYTES = crfr_pkg::MAX_IMAGE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [crfr_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [1:0]                      event_kind,
  output logic      [7:0]                      command_code,
  output logic      [15:0]                     target_id,
  output logic      [15:0]                     sender_id,
  output logic      [10:0]                     frame_length,
  output logic      [11:0]                     discard_count,
  output logic      [1:0]                      session_phase,
  output logic      [15:0]                     chunk_number,
  output logic                                 update_status,
  output logic      [31:0]                     write_offset,
  output logic      [10:0]                     payload_length,
  output logic                                 last_result
);

  import crfr_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam int SW = ((CW > 11) ? CW : 11) + 1;
  localparam logic [31:0] MAX_IMG = 32'(MAX_IMAGE_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN, S_SCAN_D, S_LEN0, S_LEN1, S_LCHK,
    S_BODY, S_BODY_D, S_CMD, S_CMD_D, S_MUL, S_FRAME, S_PUSH, S_FLUSH
  } state_t;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] v);
    logic [SW-1:0] t;
    t = (v >= SW'(BUF_DEPTH)) ? v - SW'(BUF_DEPTH) : v;
    return t[AW-1:0];
  endfunction

  state_t      state;
  logic [7:0]  head_byte, tail_byte, cmd_start, cmd_update, cmd_end;
  logic [15:0] own_id;
  logic [10:0] min_len, max_len;

  logic [CW-1:0] fill, idx;
  logic [AW-1:0] scan;
  logic [10:0]   k;
  logic [15:0]   d16;
  logic [7:0]    dlo, sum;
  logic          sum_ok;
  logic [7:0]    f_cmd;
  logic [15:0]   f_tgt, f_snd, f_8, f_16;
  logic [31:0]   f_12, f_18, prod;
  logic [1:0]    n;
  logic          has_pend;
  row_t          pend, new_row, out_row;
  logic          out_last;

  logic [1:0]  phase;
  logic [15:0] image_version, chunk_size, last_chunk;
  logic [31:0] image_total_size, image_crc;

  logic [10:0]   emin, dl;
  logic [SW-1:0] avail, rd_off;
  logic [AW-1:0] raddr, waddr;
  logic [7:0]    rdata;
  logic          we, accept, out_free, cfg_wr, out_load;
  logic [CW-1:0] disc_amt;
  row_t          disc_row, frame_row;
  logic          addressed, is_sta, is_upd, is_end;
  logic [SW-1:0] frame_end;

  assign pready   = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = has_pend && out_free && ((state == S_PUSH) || (state == S_FLUSH));
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign emin     = (min_len < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : min_len;
  assign dl       = d16[10:0];
  assign avail    = SW'(fill) - SW'(idx);
  assign we       = accept;
  assign waddr    = wrap(SW'(scan) + SW'(fill));
  assign frame_end = SW'(idx) + SW'(dl);

  always_comb begin
    case (state)
      S_SCAN_D: rd_off = SW'(idx) + SW'(1);
      S_LEN0:   rd_off = SW'(idx) + SW'(2);
      S_BODY:   rd_off = SW'(idx) + SW'(k);
      S_CMD:    rd_off = SW'(idx) + SW'(3);
      default:  rd_off = SW'(idx);
    endcase
  end
  assign raddr = wrap(SW'(scan) + rd_off);

  crfr_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (rx_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    unique case (paddr[4:2])
      REG_HEAD:    prdata = {24'd0, head_byte};
      REG_TAIL:    prdata = {24'd0, tail_byte};
      REG_OWN_ID:  prdata = {16'd0, own_id};
      REG_MIN_LEN: prdata = {21'd0, min_len};
      REG_MAX_LEN: prdata = {21'd0, max_len};
      REG_CMD_STA: prdata = {24'd0, cmd_start};
      REG_CMD_UPD: prdata = {24'd0, cmd_update};
      REG_CMD_END: prdata = {24'd0, cmd_end};
      default:     prdata = 32'd0;
    endcase
  end

  always_comb begin
    disc_amt = (state == S_IDLE) ? CW'(1) : idx;
    disc_row = '0;
    disc_row.kind  = EV_DISCARD;
    disc_row.disc  = (SW'(disc_amt) > SW'(DISC_MAX)) ? 12'(DISC_MAX) : 12'(disc_amt);
    disc_row.phase = phase;
    disc_row.chunk = last_chunk;
  end

  always_comb begin
    addressed = (own_id == f_tgt) || (own_id == ANY_ID);
    is_sta    = addressed && (f_cmd == cmd_start);
    is_upd    = addressed && !is_sta && (f_cmd == cmd_update);
    is_end    = addressed && !is_sta && !is_upd && (f_cmd == cmd_end);
    frame_row = '0;
    frame_row.kind  = addressed ? EV_OWN : EV_OTHER;
    frame_row.cmd   = f_cmd;
    frame_row.tgt   = f_tgt;
    frame_row.snd   = f_snd;
    frame_row.flen  = dl;
    frame_row.disc  = (SW'(idx) > SW'(DISC_MAX)) ? 12'(DISC_MAX) : 12'(idx);
    frame_row.phase = phase;
    frame_row.chunk = last_chunk;
    if (is_sta) begin
      frame_row.phase = PH_STARTED;
    end else if (is_upd) begin
      frame_row.phase = PH_UPDATING;
      frame_row.chunk = f_8;
      frame_row.woff  = prod;
      if ((dl > MIN_UPD_LEN) && (prod < MAX_IMG)) begin
        frame_row.status = 1'b0;
        frame_row.plen   = (dl >= FRAME_OVH) ? dl - FRAME_OVH : 11'd0;
      end else begin
        frame_row.status = 1'b1;
      end
    end else if (is_end) begin
      frame_row.phase = PH_FINISHED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      head_byte        <= 8'd0;
      tail_byte        <= 8'd0;
      own_id           <= ANY_ID;
      min_len          <= 11'd8;
      max_len          <= 11'd1200;
      cmd_start        <= 8'd0;
      cmd_update       <= 8'd0;
      cmd_end          <= 8'd0;
      fill             <= '0;
      scan             <= '0;
      phase            <= PH_IDLE;
      image_version    <= '0;
      image_total_size <= '0;
      chunk_size       <= '0;
      image_crc        <= '0;
      last_chunk       <= '0;
      n                <= '0;
      has_pend         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (paddr[4:2])
          REG_HEAD:    head_byte  <= pwdata[7:0];
          REG_TAIL:    tail_byte  <= pwdata[7:0];
          REG_OWN_ID:  own_id     <= pwdata[15:0];
          REG_MIN_LEN: min_len    <= pwdata[10:0];
          REG_MAX_LEN: max_len    <= pwdata[10:0];
          REG_CMD_STA: cmd_start  <= pwdata[7:0];
          REG_CMD_UPD: cmd_update <= pwdata[7:0];
          REG_CMD_END: cmd_end    <= pwdata[7:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            n        <= '0;
            has_pend <= 1'b0;
            if (SW'(fill) >= SW'(BUF_DEPTH)) begin
              scan    <= wrap(SW'(scan) + SW'(1));
              new_row <= disc_row;
              state   <= S_PUSH;
            end else begin
              fill  <= fill + CW'(1);
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          idx <= '0;
          if ((n == 2'd2) || (SW'(fill) < SW'(emin))) begin
            state <= S_FLUSH;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx == fill) begin
            new_row <= disc_row;
            scan    <= wrap(SW'(scan) + SW'(idx));
            fill    <= fill - idx;
            state   <= S_PUSH;
          end else begin
            state <= S_SCAN_D;
          end
        end
        S_SCAN_D: begin
          if (rdata != head_byte) begin
            idx   <= idx + CW'(1);
            state <= S_SCAN;
          end else if (avail < SW'(emin)) begin
            new_row <= disc_row;
            scan    <= wrap(SW'(scan) + SW'(idx));
            fill    <= fill - idx;
            state   <= S_PUSH;
          end else begin
            state <= S_LEN0;
          end
        end
        S_LEN0: begin
          dlo   <= rdata;
          state <= S_LEN1;
        end
        S_LEN1: begin
          d16   <= {rdata, dlo};
          state <= S_LCHK;
        end
        S_LCHK: begin
          if ((d16 > 16'(max_len)) || (d16 < 16'(emin))) begin
            idx   <= idx + CW'(1);
            state <= S_SCAN;
          end else if (avail < SW'(dl)) begin
            if (idx == '0) begin
              state <= S_FLUSH;
            end else begin
              new_row <= disc_row;
              scan    <= wrap(SW'(scan) + SW'(idx));
              fill    <= fill - idx;
              state   <= S_PUSH;
            end
          end else begin
            k      <= 11'd1;
            sum    <= 8'd0;
            sum_ok <= 1'b0;
            f_tgt  <= '0;
            f_snd  <= '0;
            f_8    <= '0;
            f_12   <= '0;
            f_16   <= '0;
            f_18   <= '0;
            state  <= S_BODY;
          end
        end
        S_BODY: begin
          state <= S_BODY_D;
        end
        S_BODY_D: begin
          if ((12'(k) + 12'd2) < 12'(dl)) begin
            sum <= sum + rdata;
          end
          case (k)
            11'd4:  f_tgt[7:0]   <= rdata;
            11'd5:  f_tgt[15:8]  <= rdata;
            11'd6:  f_snd[7:0]   <= rdata;
            11'd7:  f_snd[15:8]  <= rdata;
            11'd8:  f_8[7:0]     <= rdata;
            11'd9:  f_8[15:8]    <= rdata;
            11'd12: f_12[7:0]    <= rdata;
            11'd13: f_12[15:8]   <= rdata;
            11'd14: f_12[23:16]  <= rdata;
            11'd15: f_12[31:24]  <= rdata;
            11'd16: f_16[7:0]    <= rdata;
            11'd17: f_16[15:8]   <= rdata;
            11'd18: f_18[7:0]    <= rdata;
            11'd19: f_18[15:8]   <= rdata;
            11'd20: f_18[23:16]  <= rdata;
            11'd21: f_18[31:24]  <= rdata;
            default: ;
          endcase
          if (k == dl - 11'd2) begin
            sum_ok <= (rdata == sum);
          end
          if (k == dl - 11'd1) begin
            if (sum_ok && (rdata == tail_byte)) begin
              state <= S_CMD;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_SCAN;
            end
          end else begin
            k     <= k + 11'd1;
            state <= S_BODY;
          end
        end
        S_CMD: begin
          state <= S_CMD_D;
        end
        S_CMD_D: begin
          f_cmd <= rdata;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= f_8 * chunk_size;
          state <= S_FRAME;
        end
        S_FRAME: begin
          new_row    <= frame_row;
          phase      <= frame_row.phase;
          last_chunk <= frame_row.chunk;
          if (is_sta) begin
            image_version    <= f_8;
            image_total_size <= f_12;
            chunk_size       <= f_16;
            image_crc        <= f_18;
          end
          scan  <= wrap(SW'(scan) + frame_end);
          fill  <= fill - CW'(frame_end);
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (!has_pend) begin
            pend     <= new_row;
            has_pend <= 1'b1;
            n        <= n + 2'd1;
            state    <= S_CHECK;
          end else if (out_free) begin
            out_row   <= pend;
            out_last  <= 1'b0;
            out_valid <= 1'b1;
            pend      <= new_row;
            n         <= n + 2'd1;
            state     <= S_CHECK;
          end
        end
        S_FLUSH: begin
          if (!has_pend) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_row   <= pend;
            out_last  <= 1'b1;
            out_valid <= 1'b1;
            has_pend  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign event_kind     = out_row.kind;
  assign command_code   = out_row.cmd;
  assign target_id      = out_row.tgt;
  assign sender_id      = out_row.snd;
  assign frame_length   = out_row.flen;
  assign discard_count  = out_row.disc;
  assign session_phase  = out_row.phase;
  assign chunk_number   = out_row.chunk;
  assign update_status  = out_row.status;
  assign write_offset   = out_row.woff;
  assign payload_length = out_row.plen;
  assign last_result    = out_last;

endmodule
`default_nettype wire

@@ design/crfr_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crfr_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module crfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
